>>> rtl/core/fdpm_pkg.sv
`default_nettype none

package fdpm_pkg;

    localparam int SYM_W       = 2;
    localparam int NUM_LETTERS = 4;
    localparam int DIST_W      = 5;
    localparam int DIST_LIMIT  = 31;
    localparam int FIELD_W     = 20;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - 2 * FIELD_W - 1;

    typedef logic [NUM_LETTERS-1:0] presence_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_BLANK   = 2'd3
    } job_op_t;

    typedef struct packed {
        logic             load;
        logic             restart;
        logic             step;
        logic [SYM_W-1:0] sym;
        presence_t        presence;
    } chain_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/fdpm_cell.sv
`default_nettype none

module fdpm_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fdpm_pkg::chain_ctl_t          ctl,
    input  logic [fdpm_pkg::SYM_W-1:0]    sym_in,
    input  logic                          act_in,
    input  logic                          d_in,
    output logic [fdpm_pkg::SYM_W-1:0]    sym_out,
    output logic                          act_out,
    output logic                          d_out,
    output logic                          d_step
);

    logic [fdpm_pkg::SYM_W-1:0] sym_reg;
    logic                       act_reg;
    logic                       d_reg;
    logic                       d_next;

    // partial fit: this pattern symbol held here and everything above held earlier
    assign d_next  = (~act_reg | ctl.presence[sym_reg]) & d_in;
    assign d_step  = d_next;
    assign d_out   = act_reg ? d_reg : 1'b1;
    assign sym_out = sym_reg;
    assign act_out = act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            d_reg   <= 1'b1;
        end else begin
            if (ctl.load || ctl.restart) begin
                act_reg <= act_in;
            end
            if (ctl.step) begin
                d_reg <= d_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load || ctl.restart) begin
            sym_reg <= sym_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fdpm_chain.sv
`default_nettype none

module fdpm_chain #(
    parameter int PATTERN_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fdpm_pkg::chain_ctl_t ctl,
    output logic                 fits
);

    logic [fdpm_pkg::SYM_W-1:0] sym_w  [PATTERN_DEPTH];
    logic [fdpm_pkg::SYM_W-1:0] sin_w  [PATTERN_DEPTH];
    logic                       act_w  [PATTERN_DEPTH];
    logic                       ain_w  [PATTERN_DEPTH];
    logic                       dout_w [PATTERN_DEPTH];
    logic                       din_w  [PATTERN_DEPTH];
    logic                       dstep_w[PATTERN_DEPTH];

    // newest pattern symbol sits in cell 0; partial fits travel toward cell 0
    genvar i;
    generate
        for (i = 0; i < PATTERN_DEPTH; i++) begin : g_cells
            if (i == 0) begin : g_head
                assign sin_w[i] = ctl.sym;
                assign ain_w[i] = 1'b1;
            end else begin : g_body
                assign sin_w[i] = sym_w[i-1];
                assign ain_w[i] = ctl.restart ? 1'b0 : act_w[i-1];
            end
            if (i == PATTERN_DEPTH - 1) begin : g_tail
                assign din_w[i] = 1'b1;
            end else begin : g_link
                assign din_w[i] = dout_w[i+1];
            end

            fdpm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .sym_in  (sin_w[i]),
                .act_in  (ain_w[i]),
                .d_in    (din_w[i]),
                .sym_out (sym_w[i]),
                .act_out (act_w[i]),
                .d_out   (dout_w[i]),
                .d_step  (dstep_w[i])
            );
        end
    endgenerate

    assign fits = dstep_w[0];

endmodule

`default_nettype wire

>>> rtl/core/fdpm_presence.sv
`default_nettype none

module fdpm_presence #(
    parameter int POSITION_BITS = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              upd_en,
    input  logic [fdpm_pkg::SYM_W-1:0]        upd_sym,
    input  logic [POSITION_BITS-1:0]          upd_pos,
    input  logic                              clr,
    input  logic [POSITION_BITS-1:0]          qry_pos,
    input  logic [fdpm_pkg::DIST_W-1:0]       radius,
    output fdpm_pkg::presence_t               presence
);

    logic [POSITION_BITS-1:0]         last_seen_reg [fdpm_pkg::NUM_LETTERS];
    logic [fdpm_pkg::NUM_LETTERS-1:0] seen_reg;
    logic [POSITION_BITS:0]           reach [fdpm_pkg::NUM_LETTERS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (clr) begin
            seen_reg <= '0;
        end else if (upd_en) begin
            seen_reg[upd_sym] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            last_seen_reg[upd_sym] <= upd_pos;
        end
    end

    // letter held at p when last seen at or after p - k
    always_comb begin
        for (int l = 0; l < fdpm_pkg::NUM_LETTERS; l++) begin
            reach[l]    = {1'b0, last_seen_reg[l]} + (POSITION_BITS+1)'(radius);
            presence[l] = seen_reg[l] && (reach[l] >= {1'b0, qry_pos});
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fuzzy_dna_pattern_matcher_top.sv
// Fuzzy DNA pattern matcher.
// s_axis carries symbols: tuser selects pattern load (0) or text (1), tdata[1:0]
// holds the nucleotide, tlast closes the pattern or the text. m_axis returns one
// result per text symbol plus, on the last text symbol, up to k flush results; the
// final one of a text carries tlast. cfg_we/cfg_wdata set the radius k.
// Pattern symbols shift into a row of PATTERN_DEPTH cells; each closed text
// position broadcasts its 4-bit letter presence word and the partial-fit bits
// move one cell toward the head at each close, so the head cell decides each fit.
// A result passes the stage-1 and stage-2 job registers and the output register.
// Throughput: one symbol per cycle while s_axis_tready is high; a last text symbol
// holds the input off while flush positions are generated, one per cycle unless stalled.
// Reset empties the pattern, the text history and the pipeline; no clearing
// pass is needed. When m_axis stalls, the output register and the two job
// stages fill and s_axis_tready drops until the result transfer happens.
`default_nettype none

module fuzzy_dna_pattern_matcher_top #(
    parameter int PATTERN_DEPTH = 1024,
    parameter int DISTANCE_MAX  = 31,
    parameter int POSITION_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fdpm_pkg::DIST_W-1:0]         cfg_wdata,     // max_distance
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fdpm_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // symbol
    input  logic [0:0]                          s_axis_tuser,  // req_type
    input  logic                                s_axis_tlast,  // last_item
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fdpm_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // pattern_fits,
                                                               // end_position, match_total
    output logic [0:0]                          m_axis_tuser,  // result_valid
    output logic                                m_axis_tlast   // last_result
);

    localparam int PW       = POSITION_BITS;
    localparam int LW       = $clog2(PATTERN_DEPTH + 1);
    localparam int CW       = (PW > LW ? PW : LW) + 1;
    localparam int XW       = PW + fdpm_pkg::FIELD_W;
    localparam int DIST_CAP = DISTANCE_MAX > fdpm_pkg::DIST_LIMIT ?
                              fdpm_pkg::DIST_LIMIT : DISTANCE_MAX;
    localparam logic [PW-1:0] POS_MAX = '1;

    typedef struct packed {
        fdpm_pkg::job_op_t            op;
        logic [PW-1:0]                pos;
        logic                         last;
        logic [fdpm_pkg::SYM_W-1:0]   sym;
    } s1_job_t;

    typedef struct packed {
        s1_job_t                      job;
        fdpm_pkg::presence_t          pres;
        logic                         rv;
    } s2_job_t;

    logic [fdpm_pkg::DIST_W-1:0]   cfg_reg;
    logic [fdpm_pkg::DIST_W-1:0]   radius;

    logic [PW-1:0]  text_idx_reg, text_idx_next;
    logic           busy_reg, busy_next;
    logic           fl_act_reg, fl_act_next;
    logic [PW-1:0]  fl_pos_reg, fl_pos_next;
    logic [PW-1:0]  fl_end_reg, fl_end_next;
    logic [LW-1:0]  pat_len_reg, pat_len_next;
    logic           pat_closed_reg, pat_closed_next;
    logic [PW-1:0]  fit_cnt_reg, fit_cnt_next;

    logic           s1_valid_reg, s1_valid_next;
    s1_job_t        s1_reg, s1_next;
    logic           s2_valid_reg, s2_valid_next;
    s2_job_t        s2_reg, s2_next;

    logic                               out_valid_reg, out_valid_next;
    logic [fdpm_pkg::M_TDATA_W-1:0]     out_data_reg, out_data_next;
    logic                               out_rv_reg, out_rv_next;
    logic                               out_last_reg, out_last_next;

    logic           acc, is_text, in_last, ovf, k_zero, p_neg, fs_neg;
    logic [fdpm_pkg::SYM_W-1:0] in_sym;
    logic [PW-1:0]  n_eff;
    logic [PW:0]    p_main, fs;
    logic           out_free, s2_pat, s2_adv, s2_ready, s1_adv, s1_ready;
    logic           pres_upd, pres_clr;
    fdpm_pkg::presence_t  pres_q;
    fdpm_pkg::chain_ctl_t ctl;
    logic           chain_fits, fits, produce, is_close;
    logic [PW-1:0]  cnt_new;
    logic [XW-1:0]  pos_wide, total_wide;

    assign radius = (cfg_reg > fdpm_pkg::DIST_W'(DIST_CAP)) ?
                    fdpm_pkg::DIST_W'(DIST_CAP) : cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // handshake and pipeline advance
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s2_pat   = (s2_reg.job.op == fdpm_pkg::OP_LOAD) ||
                      (s2_reg.job.op == fdpm_pkg::OP_RESTART);
    assign s2_adv   = s2_valid_reg && (s2_pat || out_free);
    assign s2_ready = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_adv;

    assign s_axis_tready = !busy_reg && s1_ready;
    assign acc     = s_axis_tvalid && s_axis_tready;
    assign is_text = s_axis_tuser[0];
    assign in_sym  = s_axis_tdata[fdpm_pkg::SYM_W-1:0];
    assign in_last = s_axis_tlast;

    assign ovf    = (text_idx_reg == POS_MAX);
    assign n_eff  = ovf ? POS_MAX - PW'(1) : text_idx_reg;
    assign k_zero = (radius == '0);
    assign p_main = {1'b0, n_eff} - (PW+1)'(radius);
    assign p_neg  = p_main[PW];
    assign fs     = {1'b0, n_eff} + (PW+1)'(1) - (PW+1)'(radius);
    assign fs_neg = fs[PW];

    assign pres_upd = acc && is_text && !ovf;
    assign pres_clr = s1_adv && s1_reg.last;

    always_comb begin
        text_idx_next   = text_idx_reg;
        busy_next       = busy_reg;
        fl_act_next     = fl_act_reg;
        fl_pos_next     = fl_pos_reg;
        fl_end_next     = fl_end_reg;
        pat_len_next    = pat_len_reg;
        pat_closed_next = pat_closed_reg;
        s1_valid_next   = s1_valid_reg;
        s1_next         = s1_reg;

        if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        if (pres_clr) begin
            text_idx_next = '0;
            busy_next     = 1'b0;
        end

        if (s1_ready) begin
            if (fl_act_reg) begin
                s1_valid_next = 1'b1;
                s1_next.op    = fdpm_pkg::OP_CLOSE;
                s1_next.pos   = fl_pos_reg;
                s1_next.last  = (fl_pos_reg == fl_end_reg);
                s1_next.sym   = '0;
                if (fl_pos_reg == fl_end_reg) begin
                    fl_act_next = 1'b0;
                end else begin
                    fl_pos_next = fl_pos_reg + PW'(1);
                end
            end else if (acc) begin
                if (!is_text) begin
                    if (text_idx_reg == '0) begin
                        s1_next.pos  = '0;
                        s1_next.last = 1'b0;
                        s1_next.sym  = in_sym;
                        if (pat_closed_reg) begin
                            pat_len_next    = LW'(1);
                            pat_closed_next = 1'b0;
                            s1_valid_next   = 1'b1;
                            s1_next.op      = fdpm_pkg::OP_RESTART;
                        end else if (pat_len_reg < LW'(PATTERN_DEPTH)) begin
                            pat_len_next  = pat_len_reg + LW'(1);
                            s1_valid_next = 1'b1;
                            s1_next.op    = fdpm_pkg::OP_LOAD;
                        end
                        if (in_last) begin
                            pat_closed_next = 1'b1;
                        end
                    end
                end else begin
                    s1_valid_next = 1'b1;
                    s1_next.sym   = in_sym;
                    s1_next.last  = in_last && k_zero;
                    if (!ovf && !p_neg) begin
                        s1_next.op  = fdpm_pkg::OP_CLOSE;
                        s1_next.pos = p_main[PW-1:0];
                    end else begin
                        s1_next.op  = fdpm_pkg::OP_BLANK;
                        s1_next.pos = '0;
                    end
                    if (!ovf) begin
                        text_idx_next = text_idx_reg + PW'(1);
                    end
                    if (in_last) begin
                        busy_next = 1'b1;
                        if (!k_zero) begin
                            fl_act_next = 1'b1;
                            fl_pos_next = fs_neg ? '0 : fs[PW-1:0];
                            fl_end_next = n_eff;
                        end
                    end
                end
            end
        end
    end

    fdpm_presence #(
        .POSITION_BITS (POSITION_BITS)
    ) u_presence (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd_en   (pres_upd),
        .upd_sym  (in_sym),
        .upd_pos  (text_idx_reg),
        .clr      (pres_clr),
        .qry_pos  (s1_reg.pos),
        .radius   (radius),
        .presence (pres_q)
    );

    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_next       = s2_reg;
        if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
        if (s1_adv) begin
            s2_valid_next = 1'b1;
            s2_next.job   = s1_reg;
            s2_next.pres  = pres_q;
            s2_next.rv    = (CW'(s1_reg.pos) + CW'(1)) >= CW'(pat_len_reg);
        end
    end

    always_comb begin
        ctl.load     = 1'b0;
        ctl.restart  = 1'b0;
        ctl.step     = 1'b0;
        ctl.sym      = s2_reg.job.sym;
        ctl.presence = s2_reg.pres;
        is_close     = 1'b0;
        produce      = 1'b0;
        unique case (s2_reg.job.op)
            fdpm_pkg::OP_LOAD:    ctl.load    = s2_adv;
            fdpm_pkg::OP_RESTART: ctl.restart = s2_adv;
            fdpm_pkg::OP_CLOSE: begin
                ctl.step = s2_adv;
                is_close = 1'b1;
                produce  = s2_adv;
            end
            fdpm_pkg::OP_BLANK:   produce     = s2_adv;
            default: ;
        endcase
    end

    fdpm_chain #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .fits    (chain_fits)
    );

    assign fits       = is_close && s2_reg.rv && chain_fits;
    assign cnt_new    = (fits && fit_cnt_reg != POS_MAX) ? fit_cnt_reg + PW'(1) : fit_cnt_reg;
    assign pos_wide   = XW'(s2_reg.job.pos);
    assign total_wide = XW'(cnt_new);

    always_comb begin
        fit_cnt_next   = fit_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_rv_next    = out_rv_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (produce) begin
            out_valid_next = 1'b1;
            out_rv_next    = is_close && s2_reg.rv;
            out_last_next  = s2_reg.job.last;
            out_data_next  = {{fdpm_pkg::M_PAD_W{1'b0}},
                              total_wide[fdpm_pkg::FIELD_W-1:0],
                              pos_wide[fdpm_pkg::FIELD_W-1:0],
                              fits};
            fit_cnt_next   = s2_reg.job.last ? '0 : cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_idx_reg   <= '0;
            busy_reg       <= 1'b0;
            fl_act_reg     <= 1'b0;
            pat_len_reg    <= '0;
            pat_closed_reg <= 1'b0;
            fit_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            text_idx_reg   <= text_idx_next;
            busy_reg       <= busy_next;
            fl_act_reg     <= fl_act_next;
            pat_len_reg    <= pat_len_next;
            pat_closed_reg <= pat_closed_next;
            fit_cnt_reg    <= fit_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fl_pos_reg   <= fl_pos_next;
        fl_end_reg   <= fl_end_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        out_data_reg <= out_data_next;
        out_rv_reg   <= out_rv_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_rv_reg;
    assign m_axis_tlast    = out_last_reg;

    a_end_job_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_reg.last |-> busy_reg && !fl_act_reg)
        else $error("end-of-text job in stage 1 while flush still running");

    a_flush_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fl_act_reg |-> fl_pos_reg <= fl_end_reg)
        else $error("flush position ran past the end of text");

    a_pat_len: assert property (@(posedge aclk) disable iff (!aresetn)
        pat_len_reg <= LW'(PATTERN_DEPTH))
        else $error("pattern length beyond cell count");

    a_fit_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tdata[0])
        else $error("fit flagged on an invalid alignment");

endmodule

`default_nettype wire
